// ----- rtl/apdv_pkg.sv -----
// Shared types, constants and the divider step for the pan/volume block.
package apdv_pkg;

   localparam int DivBits = 32;
   localparam int RemBits = 16;
   localparam logic [16:0] PanBias = 17'sd40;
   localparam logic [19:0] PanRecip = 20'd671089;
   localparam int PanShift = 24;
   localparam logic [9:0] PanCenter = 10'd64;

   typedef enum logic [2:0] {
      REG_DEPTH_LOW  = 3'd0,
      REG_DEPTH_HIGH = 3'd1,
      REG_ATTEN_NEAR = 3'd2,
      REG_ATTEN_FAR  = 3'd3,
      REG_VOL_FLOOR  = 3'd4,
      REG_VOL_PEAK   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [15:0] pos_x;
      logic [15:0]        depth;
   } req_word_type;

   typedef struct packed {
      logic [7:0] pan;
      logic [6:0] volume;
   } rsp_word_type;

   typedef struct packed {
      logic [DivBits-1:0] num;
      logic [RemBits-1:0] rem;
      logic               neg;
      logic [7:0]         pan;
   } div_stage_type;

   // one restoring step: quotient bit shifts into num
   function automatic div_stage_type div_step(div_stage_type s, logic [RemBits-1:0] d);
      div_stage_type r;
      logic [RemBits:0] t;
      logic [RemBits:0] diff;
      r = s;
      t = {s.rem, s.num[DivBits-1]};
      diff = t - {1'b0, d};
      if (t >= {1'b0, d}) begin
         r.rem = diff[RemBits-1:0];
         r.num = {s.num[DivBits-2:0], 1'b1};
      end else begin
         r.rem = t[RemBits-1:0];
         r.num = {s.num[DivBits-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

// ----- rtl/audio_pan_distance_volume_top.sv -----
// Top level: pipelined stereo pan and distance volume.
// Throughput: one word per cycle while no valid rsp word is stalled; each
// signed divide by the attenuation range (far minus near) is a 32-stage
// restoring pipeline, and two of them run in series.
// The whole pipeline advances together; it holds only while a valid rsp word is stalled.
// Reset (synchronous, active high) clears all valid bits and loads the
// register defaults; data registers are not reset.
module audio_pan_distance_volume_top
   import apdv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word,
   input  logic         csr_write,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data
);

   logic signed [15:0] dlow_ff, dhigh_ff;
   logic [15:0]        near_ff, far_ff;
   logic [7:0]         floor_ff, peak_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dlow_ff  <= 16'sd0;
         dhigh_ff <= 16'sd32767;
         near_ff  <= 16'd0;
         far_ff   <= 16'd0;
         floor_ff <= 8'd0;
         peak_ff  <= 8'd127;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            REG_DEPTH_LOW:  dlow_ff  <= csr_data;
            REG_DEPTH_HIGH: dhigh_ff <= csr_data;
            REG_ATTEN_NEAR: near_ff  <= csr_data;
            REG_ATTEN_FAR:  far_ff   <= csr_data;
            REG_VOL_FLOOR:  floor_ff <= csr_data[7:0];
            REG_VOL_PEAK:   peak_ff  <= csr_data[7:0];
            default: ;
         endcase
      end
   end

   // range terms: the user must keep them static while words are in flight; the block does not enforce it
   logic signed [16:0] rng;
   logic               rng_neg, rng_zero;
   logic [15:0]        rng_mag;
   logic signed [8:0]  vdiff;
   logic signed [16:0] rng_negated;
   assign rng = $signed({1'b0, far_ff}) - $signed({1'b0, near_ff});
   assign rng_neg = rng[16];
   assign rng_zero = (rng == 17'sd0);
   assign rng_negated = -rng;
   assign rng_mag = rng_neg ? rng_negated[15:0] : rng[15:0];
   assign vdiff = $signed({1'b0, peak_ff}) - $signed({1'b0, floor_ff});

   logic adv;
   assign adv = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // stage 1
   logic               v1_ff;
   logic               pneg1_ff;
   logic [18:0]        pm1_ff;
   logic signed [16:0] dcl1_ff;
   logic signed [16:0] n_in, n_abs, dsx, dlo, dhi, dcl_in;
   assign n_in = $signed({req_word.pos_x[15], req_word.pos_x}) + $signed(PanBias);
   assign n_abs = n_in[16] ? -n_in : n_in;
   assign dsx = $signed({1'b0, req_word.depth});
   assign dlo = $signed({dlow_ff[15], dlow_ff});
   assign dhi = $signed({dhigh_ff[15], dhigh_ff});
   always_comb begin
      if (dsx < dlo) begin
         dcl_in = dlo;
      end else if (dhi < dsx) begin
         dcl_in = dhi;
      end else begin
         dcl_in = dsx;
      end
   end

   // stage 2
   logic               v2_ff, pneg2_ff;
   logic [38:0]        pprod2_ff;
   logic signed [17:0] delta2_ff;

   // stage 3
   logic               v3_ff;
   logic [7:0]         pan3_ff;
   logic [31:0]        sq3_ff;
   logic [13:0]        pq;
   logic signed [9:0]  pv;
   logic [35:0]        sq_full;
   assign pq = pprod2_ff[PanShift +: 14];
   assign pv = pneg2_ff ? $signed(PanCenter) - $signed({1'b0, pq[8:0]})
                        : $signed(PanCenter) + $signed({1'b0, pq[8:0]});
   logic [7:0] pan_in;
   always_comb begin
      if (pq > 14'd255 || pv < 10'sd0 || pv > 10'sd255) begin
         pan_in = 8'hFF;
      end else begin
         pan_in = pv[7:0];
      end
   end
   assign sq_full = $signed(delta2_ff) * $signed(delta2_ff);

   // divider A and B stage arrays: index 0 is the load stage
   logic          va_ff [0:DivBits];
   div_stage_type da_ff [0:DivBits];
   logic          vb_ff [0:DivBits];
   div_stage_type db_ff [0:DivBits];
   div_stage_type da_load, db_load;
   logic [31:0]   sq_neg;
   assign sq_neg = -sq3_ff;
   always_comb begin
      da_load.num = sq3_ff[31] ? sq_neg : sq3_ff;
      da_load.rem = '0;
      da_load.neg = sq3_ff[31] ^ rng_neg;
      da_load.pan = pan3_ff;
   end

   // stage after divider A: attenuation sign restore
   logic        v5_ff;
   logic [31:0] att5_ff;
   logic [7:0]  pan5_ff;
   logic [31:0] qa;
   assign qa = da_ff[DivBits].num;

   // product with volume span
   logic        v6_ff;
   logic [31:0] prod6_ff;
   logic [7:0]  pan6_ff;
   logic [40:0] prod_full;
   assign prod_full = $signed(att5_ff) * $signed(vdiff);

   logic [31:0] prod_neg;
   assign prod_neg = -prod6_ff;
   always_comb begin
      db_load.num = prod6_ff[31] ? prod_neg : prod6_ff;
      db_load.rem = '0;
      db_load.neg = prod6_ff[31] ^ rng_neg;
      db_load.pan = pan6_ff;
   end

   // output
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;
   logic [31:0]  qb, att2, vsum;
   logic [6:0]   vol_in;
   assign qb = db_ff[DivBits].num;
   assign att2 = db_ff[DivBits].neg ? -qb : qb;
   assign vsum = att2 + {24'd0, floor_ff};
   always_comb begin
      if (rng_zero) begin
         vol_in = floor_ff[7] ? 7'h7F : floor_ff[6:0];
      end else if (vsum >= 32'd128) begin
         vol_in = 7'h7F;
      end else begin
         vol_in = vsum[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= DivBits; i++) begin
            va_ff[i] <= 1'b0;
            vb_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         v1_ff <= req_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         va_ff[0] <= v3_ff;
         for (int i = 1; i <= DivBits; i++) begin
            va_ff[i] <= va_ff[i-1];
         end
         v5_ff <= va_ff[DivBits];
         v6_ff <= v5_ff;
         vb_ff[0] <= v6_ff;
         for (int i = 1; i <= DivBits; i++) begin
            vb_ff[i] <= vb_ff[i-1];
         end
         rsp_valid_ff <= vb_ff[DivBits];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pneg1_ff <= n_in[16];
         pm1_ff <= {n_abs[15:0], 3'b000};
         dcl1_ff <= dcl_in;
         pneg2_ff <= pneg1_ff;
         pprod2_ff <= pm1_ff * PanRecip;
         delta2_ff <= $signed({2'b00, far_ff}) - $signed({dcl1_ff[16], dcl1_ff});
         pan3_ff <= pan_in;
         sq3_ff <= sq_full[31:0];
         da_ff[0] <= da_load;
         for (int i = 1; i <= DivBits; i++) begin
            da_ff[i] <= div_step(da_ff[i-1], rng_mag);
         end
         att5_ff <= da_ff[DivBits].neg ? -qa : qa;
         pan5_ff <= da_ff[DivBits].pan;
         prod6_ff <= prod_full[31:0];
         pan6_ff <= pan5_ff;
         db_ff[0] <= db_load;
         for (int i = 1; i <= DivBits; i++) begin
            db_ff[i] <= div_step(db_ff[i-1], rng_mag);
         end
         rsp_word_ff.pan <= db_ff[DivBits].pan;
         rsp_word_ff.volume <= vol_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

   a_hold_pipe: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(va_ff[DivBits]) && $stable(vb_ff[0]) && $stable(v3_ff))
      else $error("pipeline valid moved while stalled");
   a_flat_vol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rng_zero && !floor_ff[7] |-> rsp_word.volume == floor_ff[6:0])
      else $error("zero range volume not floor");
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no pending output");

endmodule

// ----- dv/audio_pan_distance_volume_checker.sv -----
// Checker: predicts pan and volume for each accepted req word and compares rsp words.
module audio_pan_distance_volume_checker
   import apdv_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_word_type req_word,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_word_type rsp_word,
   input  logic         csr_write,
   input  logic [2:0]   csr_index,
   input  logic [15:0]  csr_data,
   output int           fail_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   int clamp_lo, clamp_hi, near_end, far_end, vol_floor, vol_peak;
   rsp_word_type expected_words[$];

   function automatic int trunc_div(int a, int b);
      if (b == -1) begin
         return -a;
      end
      return a / b;
   endfunction

   function automatic rsp_word_type predict_pan_volume(req_word_type w);
      rsp_word_type r;
      int sx, d, pan, range, delta, att, vol;
      sx = int'(w.pos_x);
      d = int'({16'd0, w.depth});
      pan = (sx + 40) * 128 / 400 + 64;
      if (pan < 0 || pan > 255) begin
         pan = 255;
      end
      if (d < clamp_lo) begin
         d = clamp_lo;
      end else if (clamp_hi < d) begin
         d = clamp_hi;
      end
      range = far_end - near_end;
      if (range == 0) begin
         vol = vol_floor;
      end else begin
         delta = far_end - d;
         att = trunc_div(delta * delta, range);
         vol = trunc_div(att * (vol_peak - vol_floor), range) + vol_floor;
      end
      if (vol < 0 || vol > 127) begin
         vol = 127;
      end
      r.pan = pan[7:0];
      r.volume = vol[6:0];
      return r;
   endfunction

   assign pending_count = expected_words.size();

   always @(posedge clock) begin
      rsp_word_type want;
      if (reset) begin
         clamp_lo <= 0;
         clamp_hi <= 32767;
         near_end <= 0;
         far_end <= 0;
         vol_floor <= 0;
         vol_peak <= 127;
         fail_count <= 0;
         expected_words.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_DEPTH_LOW:  clamp_lo <= int'($signed(csr_data));
               REG_DEPTH_HIGH: clamp_hi <= int'($signed(csr_data));
               REG_ATTEN_NEAR: near_end <= int'({16'd0, csr_data});
               REG_ATTEN_FAR:  far_end <= int'({16'd0, csr_data});
               REG_VOL_FLOOR:  vol_floor <= int'({24'd0, csr_data[7:0]});
               REG_VOL_PEAK:   vol_peak <= int'({24'd0, csr_data[7:0]});
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_words.push_back(predict_pan_volume(req_word));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               if (fail_count < 10) begin
                  $display("unexpected rsp word: pan %0d volume %0d",
                           rsp_word.pan, rsp_word.volume);
               end
               fail_count <= fail_count + 1;
            end else begin
               want = expected_words.pop_front();
               if (want.pan !== rsp_word.pan || want.volume !== rsp_word.volume) begin
                  if (fail_count < 10) begin
                     $display("mismatch: expected pan %0d volume %0d, got pan %0d volume %0d",
                              want.pan, want.volume, rsp_word.pan, rsp_word.volume);
                  end
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

// ----- dv/tb_audio_pan_distance_volume_top.sv -----
// Testbench top: stimulus, configuration phases and verdict for the pan/volume block.
module tb_audio_pan_distance_volume_top;
   import apdv_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [2:0] UNUSED_INDEX = 3'd6;
   localparam logic [2:0] SPARE_INDEX = 3'd7;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic csr_write = 1'b0;
   logic [2:0] csr_index = '0;
   logic [15:0] csr_data = '0;
   int fail_count, pending_count;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_off = 1'b0;
   int hold_cycles = 0;

   always #5 clock = ~clock;

   audio_pan_distance_volume_top dut (.*);

   audio_pan_distance_volume_checker checker_i (.*);

   always @(posedge clock) begin
      if (hold_off) begin
         rsp_stall <= 1'b1;
         hold_cycles <= hold_cycles + 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_word(logic [15:0] x, logic [15:0] d);
      req_valid <= 1'b1;
      req_word <= '{pos_x: x, depth: d};
      do @(posedge clock); while (req_stall);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic write_reg(logic [2:0] idx, logic [15:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic load_settings(logic [15:0] lo, logic [15:0] hi, logic [15:0] nr,
                                logic [15:0] fr, logic [15:0] fl, logic [15:0] pk);
      drain_pipe();
      write_reg(REG_DEPTH_LOW, lo);
      write_reg(REG_DEPTH_HIGH, hi);
      write_reg(REG_ATTEN_NEAR, nr);
      write_reg(REG_ATTEN_FAR, fr);
      write_reg(REG_VOL_FLOOR, fl);
      write_reg(REG_VOL_PEAK, pk);
   endtask

   task automatic random_burst(int count, int near_v, int far_v);
      logic [15:0] x, d;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(5))
            0: x = 16'($urandom_range(1400)) - 16'd700;
            1: x = $urandom_range(1) ? 16'h7fff : 16'h8000;
            default: x = 16'($urandom);
         endcase
         case ($urandom_range(3))
            0: d = 16'($urandom);
            1: d = $urandom_range(1) ? 16'hffff : 16'h0000;
            default: d = 16'($urandom_range(near_v < far_v ? near_v : far_v,
                                            near_v < far_v ? far_v : near_v));
         endcase
         send_word(x, d);
      end
   endtask

   initial begin
      logic [15:0] nr, fr;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, pan saturation edges, default settings
      send_word(16'h8000, 16'h0000);
      send_word(16'h7fff, 16'hffff);
      send_word(16'hffd8, 16'd100);
      send_word(-16'sd240, 16'd1);
      send_word(-16'sd241, 16'd2);
      send_word(16'd559, 16'h7fff);
      send_word(16'd560, 16'h8000);
      send_word(16'd0, 16'h5555);
      load_settings(16'd100, 16'd50, 16'd0, 16'd1000, 16'd10, 16'd120);
      send_word(16'd0, 16'd20);
      send_word(16'd0, 16'd75);
      send_word(16'd0, 16'd200);
      load_settings(16'h8000, 16'h7fff, 16'd0, 16'hffff, 16'd0, 16'd255);
      send_word(16'd10, 16'd0);
      send_word(16'd10, 16'h7fff);
      send_word(16'd10, 16'hffff);
      load_settings(16'h8000, 16'h7fff, 16'd1000, 16'd200, 16'd255, 16'd0);
      send_word(16'd10, 16'd0);
      send_word(16'd10, 16'd600);
      send_word(16'd10, 16'd5000);
      load_settings(16'h8000, 16'h7fff, 16'd101, 16'd100, 16'd3, 16'd200);
      send_word(16'd10, 16'd0);
      send_word(16'd10, 16'd100);
      load_settings(16'h0000, 16'h7fff, 16'd500, 16'd500, 16'd200, 16'd5);
      write_reg(UNUSED_INDEX, 16'hffff);
      write_reg(SPARE_INDEX, 16'h1234);
      send_word(16'd10, 16'd500);
      send_word(16'h8000, 16'hffff);

      for (int phase = 0; phase < 16; phase++) begin
         nr = 16'($urandom_range(2000));
         fr = 16'($urandom_range(3000));
         case (phase % 4)
            0: load_settings(16'd0, 16'h7fff, nr, fr, 16'($urandom_range(127)),
                             16'($urandom_range(127)));
            1: load_settings(16'($urandom), 16'($urandom), nr, fr, 16'($urandom),
                             16'($urandom));
            2: load_settings(16'h8000, 16'h7fff, 16'd0, 16'hffff,
                             16'($urandom_range(255)), 16'($urandom_range(255)));
            default: load_settings(16'd0, 16'd40000, fr, nr, 16'd255, 16'd0);
         endcase
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         if (phase == 5) begin
            hold_off = 1'b1;
            fork
               begin
                  while (hold_cycles < 300) @(posedge clock);
                  hold_off = 1'b0;
               end
               random_burst(100, nr, fr);
            join
         end else begin
            random_burst(100, nr, fr);
         end
         if (phase == 8) begin
            drain_pipe();
         end
      end

      drain_pipe();
      if (fail_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Regression FAIL");
      $finish;
   end

endmodule
